FILE: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker icos_chk.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error("%m: implication check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error("%m: next-cycle check failed");

`endif

FILE: rtl/core/icos_pkg.sv
// Package for the icosphere subdivider: sizes, codes, sequencer states
// and the icosahedron vertex table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package icos_pkg;

	localparam int VERTEX_DEPTH    = 1024;
	localparam int EDGE_ENTRIES    = 512;
	localparam int COORD_FRAC_BITS = 14;

	localparam int IDX_W    = 10;
	localparam int CNT_W    = 11;
	localparam int FILL_W   = 10;
	localparam int CADDR_W  = $clog2(EDGE_ENTRIES);
	localparam int VADDR_W  = $clog2(VERTEX_DEPTH);
	localparam int COORD_W  = 16;
	localparam int LEN2_W   = 30;
	localparam int ROOT_W   = 16;
	localparam int DIVD_W   = COORD_W + COORD_FRAC_BITS;
	localparam int VTX_W    = 3 * COORD_W;
	localparam int ENTRY_W  = 3 * IDX_W;
	localparam int ICO_COUNT = 12;

	localparam logic [1:0] OP_RESTART = 2'd0;
	localparam logic [1:0] OP_PASS    = 2'd1;
	localparam logic [1:0] OP_SUBDIV  = 2'd2;

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_TRI    = 1'b1;

	// 0.5257311121 and 0.8506508084 in Q2.14, rounded
	localparam logic signed [COORD_W-1:0] ICO_S = 16'sd8614;
	localparam logic signed [COORD_W-1:0] ICO_L = 16'sd13937;
	localparam logic signed [COORD_W-1:0] ICO_Z = 16'sd0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_ROOM,
		ST_EDGE,
		ST_RDA,
		ST_RDB,
		ST_SUM,
		ST_SQ,
		ST_SQRTGO,
		ST_SQRTW,
		ST_DIVGO,
		ST_DIVW,
		ST_WRITE,
		ST_TRI
	} st_t;

	function automatic logic [VTX_W-1:0] ico_vertex(input logic [3:0] i);
		logic [VTX_W-1:0] v;
		case (i)
			4'd0:    v = {-ICO_S,  ICO_L,  ICO_Z};
			4'd1:    v = { ICO_S,  ICO_L,  ICO_Z};
			4'd2:    v = {-ICO_S, -ICO_L,  ICO_Z};
			4'd3:    v = { ICO_S, -ICO_L,  ICO_Z};
			4'd4:    v = { ICO_Z, -ICO_S,  ICO_L};
			4'd5:    v = { ICO_Z,  ICO_S,  ICO_L};
			4'd6:    v = { ICO_Z, -ICO_S, -ICO_L};
			4'd7:    v = { ICO_Z,  ICO_S, -ICO_L};
			4'd8:    v = { ICO_L,  ICO_Z, -ICO_S};
			4'd9:    v = { ICO_L,  ICO_Z,  ICO_S};
			4'd10:   v = {-ICO_L,  ICO_Z, -ICO_S};
			4'd11:   v = {-ICO_L,  ICO_Z,  ICO_S};
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/icosphere_subdivider.sv
// Restart and new-pass items only reset counters; a subdivide item runs the corner check and
// edge cache scan, passes each edge already cached or repeated, and for each new vertex takes
// a 15-step square root, then (if nonzero) a 30-step divide per coordinate, plus 4 triangles.
// One item at a time; busy stays high until its last result has been issued.
// Each result shows for one cycle under valid; the receiver cannot stall.
// Reset (arst_n low, asynchronous) restores the 12 base vertices and empties the cache.
`timescale 1ns / 1ps
`default_nettype none

module icosphere_subdivider import icos_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [1:0]                op,
	input  wire logic [IDX_W-1:0]          corner_a,
	input  wire logic [IDX_W-1:0]          corner_b,
	input  wire logic [IDX_W-1:0]          corner_c,
	output logic                           valid,
	output logic                           kind,
	output logic [IDX_W-1:0]               index_0,
	output logic [IDX_W-1:0]               index_1,
	output logic [IDX_W-1:0]               index_2,
	output logic signed [COORD_W-1:0]      pos_x,
	output logic signed [COORD_W-1:0]      pos_y,
	output logic signed [COORD_W-1:0]      pos_z,
	output logic                           fault,
	output logic                           last
);

	st_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q;
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0]  va_q, vb_q, vc_q;
	logic [IDX_W-1:0]  lo_q [0:2];
	logic [IDX_W-1:0]  hi_q [0:2];
	logic [IDX_W-1:0]  mid_q [0:2];
	logic [2:0]        hit_q, dup_q;
	logic              dsel2_q;
	logic [1:0]        e_q, k_q;
	logic [FILL_W-1:0] rd_q;
	logic              pend_q;
	logic signed [COORD_W-1:0] m_q [0:2];
	logic signed [COORD_W-1:0] p_q [0:2];
	logic [LEN2_W-1:0] len2_q;
	logic [ROOT_W-1:0] len_q;
	logic [VTX_W-1:0]  pa_q;

	logic [VTX_W-1:0]   vmem [0:VERTEX_DEPTH-1];
	logic [VTX_W-1:0]   vdat_q, vconst_q;
	logic               vlow_q;
	logic [VTX_W-1:0]   vrd;
	logic [ENTRY_W-1:0] cmem [0:EDGE_ENTRIES-1];
	logic [ENTRY_W-1:0] cdat_q;

	// outputs of the sequencer
	logic              vwe, cwe, sq_start, dv_start;
	logic              emit_fault, emit_vtx, emit_tri;
	logic [VADDR_W-1:0] vaddr;
	logic [CADDR_W-1:0] caddr;

	logic              sq_done, dv_done;
	logic [ROOT_W-1:0] sq_root;
	logic [DIVD_W-1:0] dv_quo;
	logic [DIVD_W-1:0] dv_dividend;
	logic [COORD_W-1:0] m_abs;

	logic [IDX_W-1:0]  klo [0:2];
	logic [IDX_W-1:0]  khi [0:2];
	logic              bad_corner;
	logic [1:0]        need;
	logic              no_room;
	logic              edge_done;
	logic signed [COORD_W:0] sum_c [0:2];
	logic signed [2*COORD_W-1:0] sq_prod;
	logic [COORD_W-1:0] q_lo;

	icos_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (len2_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign m_abs       = m_q[k_q][COORD_W-1] ? 16'(-m_q[k_q]) : m_q[k_q];
	assign dv_dividend = {m_abs, COORD_FRAC_BITS'(0)};

	icos_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (dv_dividend),
		.divisor  (len_q),
		.done     (dv_done),
		.quotient (dv_quo)
	);

	always_comb begin
		klo[0] = (corner_a < corner_b) ? corner_a : corner_b;
		khi[0] = (corner_a < corner_b) ? corner_b : corner_a;
		klo[1] = (corner_b < corner_c) ? corner_b : corner_c;
		khi[1] = (corner_b < corner_c) ? corner_c : corner_b;
		klo[2] = (corner_c < corner_a) ? corner_c : corner_a;
		khi[2] = (corner_c < corner_a) ? corner_a : corner_c;
	end

	assign bad_corner = ({1'b0, va_q} >= cnt_q) || ({1'b0, vb_q} >= cnt_q) ||
		({1'b0, vc_q} >= cnt_q);
	assign need = 2'(!hit_q[0] && !dup_q[0]) + 2'(!hit_q[1] && !dup_q[1]) +
		2'(!hit_q[2] && !dup_q[2]);
	assign no_room = ({1'b0, cnt_q} + 12'(need) > 12'(VERTEX_DEPTH)) ||
		({1'b0, fill_q} + 11'(need) > 11'(EDGE_ENTRIES));
	assign edge_done = dup_q[e_q] || hit_q[e_q];

	assign vrd = vlow_q ? vconst_q : vdat_q;

	always_comb begin
		sum_c[0] = {pa_q[47], pa_q[47:32]} + {vrd[47], vrd[47:32]};
		sum_c[1] = {pa_q[31], pa_q[31:16]} + {vrd[31], vrd[31:16]};
		sum_c[2] = {pa_q[15], pa_q[15:0]}  + {vrd[15], vrd[15:0]};
	end

	assign sq_prod = m_q[k_q] * m_q[k_q];
	assign q_lo    = dv_quo[COORD_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start && op == OP_SUBDIV) state_d = ST_CHECK;
			ST_CHECK:  state_d = bad_corner ? ST_IDLE : ST_SCAN;
			ST_SCAN:   if (rd_q >= fill_q && !pend_q) state_d = ST_ROOM;
			ST_ROOM:   state_d = no_room ? ST_IDLE : ST_EDGE;
			ST_EDGE: begin
				if (!edge_done)
					state_d = ST_RDA;
				else if (e_q == 2'd2)
					state_d = ST_TRI;
			end
			ST_RDA:    state_d = ST_RDB;
			ST_RDB:    state_d = ST_SUM;
			ST_SUM:    state_d = ST_SQ;
			ST_SQ:     if (k_q == 2'd2) state_d = ST_SQRTGO;
			ST_SQRTGO: state_d = ST_SQRTW;
			ST_SQRTW:  if (sq_done) state_d = (sq_root == '0) ? ST_WRITE : ST_DIVGO;
			ST_DIVGO:  state_d = ST_DIVW;
			ST_DIVW:   if (dv_done) state_d = (k_q == 2'd2) ? ST_WRITE : ST_DIVGO;
			ST_WRITE:  state_d = (e_q == 2'd2) ? ST_TRI : ST_EDGE;
			ST_TRI:    if (k_q == 2'd3) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy       = 1'b1;
		vwe        = 1'b0;
		cwe        = 1'b0;
		sq_start   = 1'b0;
		dv_start   = 1'b0;
		emit_fault = 1'b0;
		emit_vtx   = 1'b0;
		emit_tri   = 1'b0;
		vaddr      = lo_q[e_q];
		caddr      = rd_q[CADDR_W-1:0];
		case (state_q)
			ST_IDLE:   busy = 1'b0;
			ST_CHECK:  emit_fault = bad_corner;
			ST_ROOM:   emit_fault = no_room;
			ST_RDB:    vaddr = hi_q[e_q];
			ST_SQRTGO: sq_start = 1'b1;
			ST_DIVGO:  dv_start = 1'b1;
			ST_WRITE: begin
				vwe      = 1'b1;
				cwe      = 1'b1;
				emit_vtx = 1'b1;
			end
			ST_TRI:    emit_tri = 1'b1;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= CNT_W'(ICO_COUNT);
			fill_q <= '0;
			e_q    <= '0;
			k_q    <= '0;
			rd_q   <= '0;
			pend_q <= 1'b0;
			hit_q  <= '0;
			dup_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start && op == OP_RESTART) begin
						cnt_q  <= CNT_W'(ICO_COUNT);
						fill_q <= '0;
					end else if (start && op == OP_PASS) begin
						fill_q <= '0;
					end
				end
				ST_CHECK: begin
					rd_q   <= '0;
					pend_q <= 1'b0;
					hit_q  <= '0;
				end
				ST_SCAN: begin
					pend_q <= rd_q < fill_q;
					if (rd_q < fill_q) rd_q <= rd_q + 1'b1;
					if (pend_q) begin
						for (int j = 0; j < 3; j++)
							if (cdat_q[ENTRY_W-1 -: IDX_W] == lo_q[j] &&
								cdat_q[2*IDX_W-1 -: IDX_W] == hi_q[j])
								hit_q[j] <= 1'b1;
					end
				end
				ST_ROOM:   e_q <= '0;
				ST_EDGE: begin
					if (edge_done) begin
						e_q <= e_q + 1'b1;
						k_q <= '0;
					end
				end
				ST_SUM:    k_q <= '0;
				ST_SQ:     k_q <= k_q + 1'b1;
				ST_SQRTW:  if (sq_done) k_q <= '0;
				ST_DIVW:   if (dv_done) k_q <= k_q + 1'b1;
				ST_WRITE: begin
					cnt_q  <= cnt_q + 1'b1;
					fill_q <= fill_q + 1'b1;
					e_q    <= e_q + 1'b1;
					k_q    <= '0;
				end
				ST_TRI:    k_q <= k_q + 1'b1;
				default:   ;
			endcase
			if (state_q == ST_IDLE && start && op == OP_SUBDIV) begin
				dup_q[0] <= 1'b0;
				dup_q[1] <= (klo[1] == klo[0]) && (khi[1] == khi[0]);
				dup_q[2] <= ((klo[2] == klo[0]) && (khi[2] == khi[0])) ||
					((klo[2] == klo[1]) && (khi[2] == khi[1]));
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			va_q <= corner_a;
			vb_q <= corner_b;
			vc_q <= corner_c;
			for (int j = 0; j < 3; j++) begin
				lo_q[j] <= klo[j];
				hi_q[j] <= khi[j];
			end
			dsel2_q <= !((klo[2] == klo[0]) && (khi[2] == khi[0]));
		end
		if (state_q == ST_SCAN && pend_q) begin
			for (int j = 0; j < 3; j++)
				if (cdat_q[ENTRY_W-1 -: IDX_W] == lo_q[j] &&
					cdat_q[2*IDX_W-1 -: IDX_W] == hi_q[j])
					mid_q[j] <= cdat_q[IDX_W-1:0];
		end
		if (state_q == ST_EDGE && dup_q[e_q]) begin
			if (e_q == 2'd1)
				mid_q[1] <= mid_q[0];
			else
				mid_q[2] <= dsel2_q ? mid_q[1] : mid_q[0];
		end
		if (state_q == ST_RDB)
			pa_q <= vrd;
		if (state_q == ST_SUM) begin
			for (int j = 0; j < 3; j++)
				m_q[j] <= sum_c[j][COORD_W:1];
			len2_q <= '0;
		end
		if (state_q == ST_SQ)
			len2_q <= len2_q + sq_prod[LEN2_W-1:0];
		if (state_q == ST_SQRTW && sq_done) begin
			len_q <= sq_root;
			for (int j = 0; j < 3; j++)
				p_q[j] <= '0;
		end
		if (state_q == ST_DIVW && dv_done)
			p_q[k_q] <= m_q[k_q][COORD_W-1] ? 16'(-q_lo) : q_lo;
		if (state_q == ST_WRITE)
			mid_q[e_q] <= cnt_q[IDX_W-1:0];
	end

	// vertex store; the base vertices come from the constant table
	always_ff @(posedge clk) begin
		if (vwe)
			vmem[cnt_q[VADDR_W-1:0]] <= {p_q[0], p_q[1], p_q[2]};
		vdat_q   <= vmem[vaddr];
		vconst_q <= ico_vertex(vaddr[3:0]);
		vlow_q   <= vaddr < VADDR_W'(ICO_COUNT);
	end

	// edge cache
	always_ff @(posedge clk) begin
		if (cwe)
			cmem[fill_q[CADDR_W-1:0]] <= {lo_q[e_q], hi_q[e_q], cnt_q[IDX_W-1:0]};
		cdat_q <= cmem[caddr];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid <= 1'b0;
		else
			valid <= emit_fault || emit_vtx || emit_tri;
	end

	always_ff @(posedge clk) begin
		kind    <= KIND_TRI;
		index_0 <= '0;
		index_1 <= '0;
		index_2 <= '0;
		pos_x   <= '0;
		pos_y   <= '0;
		pos_z   <= '0;
		fault   <= emit_fault;
		last    <= emit_fault || (emit_tri && k_q == 2'd3);
		if (emit_vtx) begin
			kind    <= KIND_VERTEX;
			index_0 <= cnt_q[IDX_W-1:0];
			pos_x   <= p_q[0];
			pos_y   <= p_q[1];
			pos_z   <= p_q[2];
		end else if (emit_tri) begin
			case (k_q)
				2'd0: begin
					index_0 <= va_q;    index_1 <= mid_q[0]; index_2 <= mid_q[2];
				end
				2'd1: begin
					index_0 <= vb_q;    index_1 <= mid_q[1]; index_2 <= mid_q[0];
				end
				2'd2: begin
					index_0 <= vc_q;    index_1 <= mid_q[2]; index_2 <= mid_q[1];
				end
				default: begin
					index_0 <= mid_q[0]; index_1 <= mid_q[1]; index_2 <= mid_q[2];
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/icos_sqrt.sv
// Iterative floor integer square root, one result bit per cycle.
// Depends on icos_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icos_sqrt import icos_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [LEN2_W-1:0] radicand,
	output logic                   done,
	output logic [ROOT_W-1:0]      root
);

	logic [LEN2_W-1:0] v_q;
	logic [LEN2_W:0]   r_q;
	logic [LEN2_W-1:0] bit_q;
	logic              run_q;
	logic              done_q;
	logic [LEN2_W:0]   trial;

	assign trial = r_q + {1'b0, bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && bit_q[0];
			if (start)
				run_q <= 1'b1;
			else if (run_q && bit_q[0])
				run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			r_q   <= '0;
			bit_q <= LEN2_W'(1) << (LEN2_W - 2);
		end else if (run_q) begin
			if ({1'b0, v_q} >= trial) begin
				v_q <= v_q - trial[LEN2_W-1:0];
				r_q <= (r_q >> 1) + {1'b0, bit_q};
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[ROOT_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/icos_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on icos_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icos_div import icos_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIVD_W-1:0] dividend,
	input  wire logic [ROOT_W-1:0] divisor,
	output logic                   done,
	output logic [DIVD_W-1:0]      quotient
);

	localparam int STEP_W = $clog2(DIVD_W);

	logic [ROOT_W-1:0] rem_q;
	logic [DIVD_W-1:0] quo_q;
	logic [ROOT_W-1:0] dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;
	logic [ROOT_W:0]   rem_sh;
	logic [ROOT_W:0]   rem_sub;
	logic              fits;

	assign rem_sh  = {rem_q, quo_q[DIVD_W-1]};
	assign fits    = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= run_q && (step_q == '0);
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(DIVD_W - 1);
			end else if (run_q) begin
				if (step_q == '0)
					run_q <= 1'b0;
				else
					step_q <= step_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? rem_sub[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/core/icos_chk.sv
// Port-level checker for icosphere_subdivider, bound to the top level.
// Depends on icos_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module icos_chk import icos_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 start,
	input wire logic                 busy,
	input wire logic [1:0]           op,
	input wire logic                 valid,
	input wire logic                 kind,
	input wire logic [IDX_W-1:0]     index_1,
	input wire logic [IDX_W-1:0]     index_2,
	input wire logic                 fault,
	input wire logic                 last
);

	`ASSERT_IMPL(a_fault_last, clk, arst_n, valid && fault, last && kind == KIND_TRI)
	`ASSERT_IMPL(a_vtx_zero, clk, arst_n, valid && kind == KIND_VERTEX, index_1 == '0 && index_2 == '0 && !last)
	`ASSERT_NEXT(a_sub_busy, clk, arst_n, start && !busy && op == OP_SUBDIV, busy)
	`ASSERT_IMPL(a_idle_last, clk, arst_n, valid && !busy, last)

endmodule

bind icosphere_subdivider icos_chk u_icos_chk (.*);

`default_nettype wire

FILE: verif/icosphere_checker.sv
// Checker for the icosphere subdivider: watches the command and result channels,
// predicts every record from its own copy of the vertex store and edge cache,
// and compares. Depends on icos_pkg.
`timescale 1ns / 1ps

module icosphere_checker import icos_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [1:0]              op,
	input  logic [IDX_W-1:0]        corner_a,
	input  logic [IDX_W-1:0]        corner_b,
	input  logic [IDX_W-1:0]        corner_c,
	input  logic                    valid,
	input  logic                    kind,
	input  logic [IDX_W-1:0]        index_0,
	input  logic [IDX_W-1:0]        index_1,
	input  logic [IDX_W-1:0]        index_2,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [COORD_W-1:0] pos_z,
	input  logic                    fault,
	input  logic                    last,
	output int                      failures,
	output int                      pending,
	output int                      vertex_total,
	output int                      vertex_records,
	output int                      fault_records
);

	typedef struct {
		logic                     kind;
		logic [IDX_W-1:0]         i0, i1, i2;
		logic signed [COORD_W-1:0] x, y, z;
		logic                     fault;
		logic                     last;
	} record_t;

	record_t    awaited_records[$];
	longint     vstore[VERTEX_DEPTH][3];
	int         vcount;
	int         edge_lo[EDGE_ENTRIES];
	int         edge_hi[EDGE_ENTRIES];
	int         edge_mid[EDGE_ENTRIES];
	int         edge_fill;

	// sign of each base coordinate; 1 = short, 2 = long component
	const int base_shape[12][3] = '{
		'{-1, 2, 0}, '{1, 2, 0}, '{-1, -2, 0}, '{1, -2, 0},
		'{0, -1, 2}, '{0, 1, 2}, '{0, -1, -2}, '{0, 1, -2},
		'{2, 0, -1}, '{2, 0, 1}, '{-2, 0, -1}, '{-2, 0, 1}
	};

	assign pending = awaited_records.size();
	assign vertex_total = vcount;

	task automatic restore_base();
		int  c;
		longint mag;
		for (int i = 0; i < 12; i++)
			for (int j = 0; j < 3; j++) begin
				c = base_shape[i][j];
				mag = (c == 1 || c == -1) ? longint'(ICO_S) : (c == 0 ? 0 : longint'(ICO_L));
				vstore[i][j] = c < 0 ? -mag : mag;
			end
		vcount = 12;
		edge_fill = 0;
	endtask

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp16(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[COORD_W-1:0];
	endfunction

	function automatic record_t mk(logic k, int i0, int i1, int i2, logic f);
		record_t r;
		r.kind = k; r.i0 = IDX_W'(i0); r.i1 = IDX_W'(i1); r.i2 = IDX_W'(i2);
		r.x = '0; r.y = '0; r.z = '0; r.fault = f; r.last = 1'b0;
		return r;
	endfunction

	task automatic queue_record(record_t r);
		awaited_records = {awaited_records, r};
	endtask

	task automatic add_fault();
		record_t r;
		r = mk(KIND_TRI, 0, 0, 0, 1'b1);
		r.last = 1'b1;
		queue_record(r);
	endtask

	task automatic predict_item(logic [1:0] code, int a, int b, int c);
		int v[3], lo[3], hi[3], mid[3], hit[3], dup[3];
		int need, q;
		longint m[3];
		longint unsigned len2, len, mag;
		record_t r;
		need = 0;
		if (code == OP_RESTART) restore_base();
		else if (code == OP_PASS) edge_fill = 0;
		else if (code == OP_SUBDIV) begin
			v[0] = a; v[1] = b; v[2] = c;
			if (a >= vcount || b >= vcount || c >= vcount) begin
				add_fault();
				return;
			end
			for (int e = 0; e < 3; e++) begin
				q = v[(e + 1) % 3];
				lo[e] = v[e] < q ? v[e] : q;
				hi[e] = v[e] < q ? q : v[e];
				hit[e] = -1;
				for (int i = 0; i < edge_fill; i++)
					if (hit[e] < 0 && edge_lo[i] == lo[e] && edge_hi[i] == hi[e]) hit[e] = i;
				dup[e] = -1;
				for (int k = 0; k < e; k++)
					if (dup[e] < 0 && lo[k] == lo[e] && hi[k] == hi[e]) dup[e] = k;
				if (hit[e] < 0 && dup[e] < 0) need++;
			end
			if (vcount + need > VERTEX_DEPTH || edge_fill + need > EDGE_ENTRIES) begin
				add_fault();
				return;
			end
			for (int e = 0; e < 3; e++) begin
				if (dup[e] >= 0) mid[e] = mid[dup[e]];
				else if (hit[e] >= 0) mid[e] = edge_mid[hit[e]];
				else begin
					mid[e] = vcount;
					len2 = 0;
					for (int i = 0; i < 3; i++) begin
						m[i] = (vstore[lo[e]][i] + vstore[hi[e]][i]) >>> 1;
						len2 += longint'(m[i] * m[i]);
					end
					len = floor_sqrt(len2);
					for (int i = 0; i < 3; i++) begin
						mag = longint'(m[i] < 0 ? -m[i] : m[i]) << COORD_FRAC_BITS;
						vstore[mid[e]][i] = len == 0 ? 0 :
							(m[i] < 0 ? -longint'(mag / len) : longint'(mag / len));
					end
					vcount++;
					edge_lo[edge_fill] = lo[e];
					edge_hi[edge_fill] = hi[e];
					edge_mid[edge_fill] = mid[e];
					edge_fill++;
					r = mk(KIND_VERTEX, mid[e], 0, 0, 1'b0);
					r.x = clamp16(vstore[mid[e]][0]);
					r.y = clamp16(vstore[mid[e]][1]);
					r.z = clamp16(vstore[mid[e]][2]);
					queue_record(r);
					vertex_records++;
				end
			end
			queue_record(mk(KIND_TRI, v[0], mid[0], mid[2], 1'b0));
			queue_record(mk(KIND_TRI, v[1], mid[1], mid[0], 1'b0));
			queue_record(mk(KIND_TRI, v[2], mid[2], mid[1], 1'b0));
			r = mk(KIND_TRI, mid[0], mid[1], mid[2], 1'b0);
			r.last = 1'b1;
			queue_record(r);
		end
	endtask

	task automatic compare_record();
		record_t w;
		if (awaited_records.size() == 0) begin
			$error("unexpected result record: kind %0d index_0 %0d", kind, index_0);
			failures++;
			return;
		end
		w = awaited_records.pop_front();
		if (w.fault) fault_records++;
		if (kind !== w.kind) begin
			$error("kind: expected %0d, got %0d", w.kind, kind); failures++;
		end
		if (index_0 !== w.i0) begin
			$error("index_0: expected %0d, got %0d", w.i0, index_0); failures++;
		end
		if (index_1 !== w.i1) begin
			$error("index_1: expected %0d, got %0d", w.i1, index_1); failures++;
		end
		if (index_2 !== w.i2) begin
			$error("index_2: expected %0d, got %0d", w.i2, index_2); failures++;
		end
		if (pos_x !== w.x) begin
			$error("pos_x: expected %0d, got %0d", w.x, pos_x); failures++;
		end
		if (pos_y !== w.y) begin
			$error("pos_y: expected %0d, got %0d", w.y, pos_y); failures++;
		end
		if (pos_z !== w.z) begin
			$error("pos_z: expected %0d, got %0d", w.z, pos_z); failures++;
		end
		if (fault !== w.fault) begin
			$error("fault: expected %0d, got %0d", w.fault, fault); failures++;
		end
		if (last !== w.last) begin
			$error("last: expected %0d, got %0d", w.last, last); failures++;
		end
	endtask

	initial begin
		failures = 0;
		vertex_records = 0;
		fault_records = 0;
		restore_base();
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restore_base();
		end else begin
			if (valid === 1'b1) compare_record();
			if (start && !busy) predict_item(op, corner_a, corner_b, corner_c);
		end
	end

endmodule

FILE: verif/testbench.sv
// Top of the icosphere subdivider testbench: clock, reset, item stimulus and verdict.
// Depends on icos_pkg, icosphere_subdivider and icosphere_checker.
`timescale 1ns / 1ps

module testbench;
	import icos_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic                     clk, arst_n, start, busy, valid, kind, fault, last;
	logic [1:0]               op;
	logic [IDX_W-1:0]         corner_a, corner_b, corner_c, index_0, index_1, index_2;
	logic signed [COORD_W-1:0] pos_x, pos_y, pos_z;
	int                       failures, pending, vertex_total, vertex_records, fault_records;
	int                       idle_cycles, items_sent, gap_pct;
	int                       prev_a, prev_b, prev_c;

	icosphere_subdivider DUT (.*);
	icosphere_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || valid) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_item(logic [1:0] code, int a, int b, int c);
		do @(negedge clk); while (busy);
		while ($urandom_range(99) < gap_pct) @(negedge clk);
		start = 1;
		op = code;
		corner_a = IDX_W'(a); corner_b = IDX_W'(b); corner_c = IDX_W'(c);
		@(negedge clk);
		start = 0;
		op = 2'($urandom);
		corner_a = IDX_W'($urandom); corner_b = IDX_W'($urandom);
		corner_c = IDX_W'($urandom);
		if (code != 2'd3) items_sent++;
		prev_a = a; prev_b = b; prev_c = c;
	endtask

	task automatic random_item(int restart_pct, int pass_pct);
		int r, a, b, c;
		r = $urandom_range(99);
		do @(negedge clk); while (busy);
		a = $urandom_range(vertex_total - 1);
		b = $urandom_range(vertex_total - 1);
		c = $urandom_range(vertex_total - 1);
		if (r < restart_pct) send_item(OP_RESTART, $urandom, $urandom, $urandom);
		else if (r < restart_pct + pass_pct) send_item(OP_PASS, $urandom, $urandom, $urandom);
		else if (r < restart_pct + pass_pct + 2) send_item(2'd3, $urandom, $urandom, $urandom);
		else if (r < restart_pct + pass_pct + 8)
			send_item(OP_SUBDIV, a, b, $urandom_range(1023, vertex_total));
		else if (r < 55)
			// share an edge with the previous triangle, reversed
			send_item(OP_SUBDIV, prev_b, prev_a, c);
		else if (r < 58) send_item(OP_SUBDIV, a, a, b);
		else send_item(OP_SUBDIV, a, b, c);
	endtask

	initial begin
		start = 0; op = 0; corner_a = 0; corner_b = 0; corner_c = 0;
		idle_cycles = 0; items_sent = 0; gap_pct = 20;
		prev_a = 0; prev_b = 1; prev_c = 2;
		arst_n = 0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: base triangle, cache hits, degenerate and antipodal edges, faults
		send_item(OP_SUBDIV, 0, 1, 2);
		send_item(OP_SUBDIV, 2, 1, 0);
		send_item(OP_SUBDIV, 0, 0, 0);
		send_item(OP_SUBDIV, 5, 5, 7);
		send_item(OP_SUBDIV, 0, 3, 0);
		send_item(OP_SUBDIV, 1023, 1023, 1023);
		send_item(OP_SUBDIV, 0, 1, vertex_total);
		send_item(OP_SUBDIV, 11, 10, 9);
		send_item(2'd3, 1023, 1023, 1023);
		send_item(OP_PASS, 0, 0, 0);
		send_item(OP_SUBDIV, 0, 1, 2);
		send_item(OP_RESTART, 1023, 1023, 1023);
		send_item(OP_SUBDIV, 4, 8, 11);
		send_item(OP_SUBDIV, 6, 7, 12);

		while (items_sent < 100) random_item(3, 6);
		gap_pct = 78;
		// no passes: the edge cache runs full
		while (items_sent < 280) random_item(0, 0);
		gap_pct = 0;
		// frequent passes without restarts: the vertex store runs full
		while (items_sent < 500) random_item(0, 10);

		while (pending != 0) @(negedge clk);
		repeat (1000) @(negedge clk);
		$display("%0d items sent, %0d new vertices, %0d fault records checked",
			items_sent, vertex_records, fault_records);
		$display("store ended at %0d vertices; %0d mismatches", vertex_total, failures);
		if (failures == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
